// ----- rtl/assert_macros.svh -----
// assertion macros included by the sorter module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rtds_pkg.sv -----
// types, constants and microcode rom of the record total sorter
package rtds_pkg;

   localparam int MAX_RECORDS          = 32;
   localparam int MAX_MARKS_PER_RECORD = 16;

   localparam int MARK_W = 10;
   localparam int ID_W   = 6;
   localparam int TOT_W  = 14;
   localparam int IDX_W  = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

   localparam int FIELD_MAX     = (1 << TOT_W) - 1;
   localparam int RAW_TOTAL_MAX = ((1 << MARK_W) - 1) * MAX_MARKS_PER_RECORD;
   localparam logic [TOT_W-1:0] TOTAL_MAX =
      TOT_W'((RAW_TOTAL_MAX > FIELD_MAX) ? FIELD_MAX : RAW_TOTAL_MAX);

   // one stored record
   typedef struct packed {
      logic [TOT_W-1:0] total;
      logic [ID_W-1:0]  id;
   } entry_type;

   // sequencer steps
   typedef enum logic [2:0] {
      STEP_IDLE   = 3'd0,
      STEP_RD_I   = 3'd1,
      STEP_LD_R   = 3'd2,
      STEP_TEST_J = 3'd3,
      STEP_CMP    = 3'd4,
      STEP_EMIT   = 3'd5,
      STEP_ADV    = 3'd6,
      STEP_DONE   = 3'd7
   } step_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_CLOSE,
      COND_J_END,
      COND_OUT_BUSY,
      COND_MORE_I
   } cond_type;

   // one control word
   typedef struct packed {
      logic     accept;
      logic     rd_j;
      logic     ld_r;
      logic     cmp;
      logic     emit;
      logic     inc_i;
      logic     clr_set;
      cond_type cond;
      step_type target;
   } ctl_type;

   function automatic ctl_type ucode(input step_type step);
      ctl_type c;
      c = '{accept: 1'b0, rd_j: 1'b0, ld_r: 1'b0, cmp: 1'b0, emit: 1'b0,
            inc_i: 1'b0, clr_set: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            c.accept = 1'b1;
            c.cond   = COND_NO_CLOSE;
            c.target = STEP_IDLE;
         end
         STEP_RD_I: begin
            c.cond = COND_NEVER;
         end
         STEP_LD_R: begin
            c.ld_r = 1'b1;
         end
         STEP_TEST_J: begin
            c.rd_j   = 1'b1;
            c.cond   = COND_J_END;
            c.target = STEP_EMIT;
         end
         STEP_CMP: begin
            c.cmp    = 1'b1;
            c.cond   = COND_ALWAYS;
            c.target = STEP_TEST_J;
         end
         STEP_EMIT: begin
            c.emit   = 1'b1;
            c.cond   = COND_OUT_BUSY;
            c.target = STEP_EMIT;
         end
         STEP_ADV: begin
            c.inc_i  = 1'b1;
            c.cond   = COND_MORE_I;
            c.target = STEP_RD_I;
         end
         STEP_DONE: begin
            c.clr_set = 1'b1;
            c.cond    = COND_ALWAYS;
            c.target  = STEP_IDLE;
         end
         default: begin
            c.cond   = COND_ALWAYS;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/row_total_then_descending_sort.sv -----
// loading: one request per cycle; a record closing the set starts the sort
// sort and output can be held by output stalls; the sort is paced by the single read port
// of the record memory, one compare per two steps
// requests are refused while the sort and output run
// reset clears the sequencer, counters, sums and flags; the record memory is not cleared
module row_total_then_descending_sort
   import rtds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] mark
   input  logic        req_tlast,   // record_end
   input  logic        req_tuser,   // set_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] record_id, [19:6] record_total
   output logic        rsp_tlast,   // last_result
   output logic        rsp_tuser    // overflow
);

`include "assert_macros.svh"

   entry_type mem_ff [MAX_RECORDS];

   step_type          pc_ff, pc_in;
   ctl_type           ctl;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TOT_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   entry_type         r_ff, r_in;
   entry_type         rdata_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              req_hs, close, store_rec, cond_hit, out_busy, out_load;
   logic              swap, j_end, more_i, last_i;
   logic [TOT_W:0]    sum_ext;
   logic [TOT_W-1:0]  sum_new;
   logic [CNT_W:0]    id_full;
   logic [CNT_W-1:0]  i_next;
   logic [IDX_W-1:0]  raddr;

   // control word of the current step
   assign ctl = ucode(pc_ff);

   // saturating record sum
   assign sum_ext = {1'b0, sum_ff} + (TOT_W+1)'(req_tdata[MARK_W-1:0]);
   assign sum_new = (sum_ext > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_ext[TOT_W-1:0];
   assign id_full = {1'b0, count_ff} + (CNT_W+1)'(1);

   // request handshake and record bookkeeping
   assign req_tready = ctl.accept;
   assign req_hs     = req_tvalid & ctl.accept;
   assign close      = req_hs & req_tlast & req_tuser;
   assign store_rec  = req_hs & req_tlast & (count_ff < CNT_W'(MAX_RECORDS));

   // sort loop conditions
   assign i_next   = CNT_W'(i_ff) + CNT_W'(1);
   assign j_end    = (j_ff >= count_ff);
   assign more_i   = (i_next < count_ff);
   assign last_i   = (i_next == count_ff);
   assign swap     = ctl.cmp & (rdata_ff.total > r_ff.total);
   assign out_busy = rsp_valid_ff & ~rsp_tready;
   assign out_load = ctl.emit & ~out_busy;
   assign raddr    = ctl.rd_j ? j_ff[IDX_W-1:0] : i_ff;

   // jump condition select
   always_comb begin
      case (ctl.cond)
         COND_NEVER:    cond_hit = 1'b0;
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_NO_CLOSE: cond_hit = ~close;
         COND_J_END:    cond_hit = j_end;
         COND_OUT_BUSY: cond_hit = out_busy;
         COND_MORE_I:   cond_hit = more_i;
         default:       cond_hit = 1'b0;
      endcase
   end

   // next step and datapath updates
   always_comb begin
      pc_in        = cond_hit ? ctl.target : step_type'(pc_ff + 3'd1);
      count_in     = count_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (req_hs) begin
         sum_in = req_tlast ? '0 : sum_new;
         if (store_rec) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (req_tlast && !store_rec) begin
            ovf_in = 1'b1;
         end
      end
      if (ctl.ld_r) begin
         r_in = rdata_ff;
         j_in = i_next;
      end
      if (ctl.cmp) begin
         j_in = j_ff + CNT_W'(1);
         if (swap) begin
            r_in = rdata_ff;
         end
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = r_ff;
         rsp_last_in  = last_i;
         rsp_ovf_in   = ovf_ff;
      end
      if (ctl.inc_i) begin
         i_in = i_next[IDX_W-1:0];
      end
      if (ctl.clr_set) begin
         count_in = '0;
         sum_in   = '0;
         ovf_in   = 1'b0;
         i_in     = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_rec) begin
         mem_ff[count_ff[IDX_W-1:0]] <= '{total: sum_new, id: ID_W'(id_full)};
      end else if (swap) begin
         mem_ff[j_ff[IDX_W-1:0]] <= r_ff;
      end
      rdata_ff <= mem_ff[raddr];
   end

   // response port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_entry_ff.total, rsp_entry_ff.id};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // checks
   `ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_RECORDS),
                 "record count beyond capacity")
   `ASSERT_IMPLY(a_cmp_in_range, clock, reset, pc_ff == STEP_CMP, j_ff < count_ff,
                 "compare index past stored records")
   `ASSERT_NEXT(a_set_cleared, clock, reset, pc_ff == STEP_DONE,
                count_ff == '0 && sum_ff == '0 && !ovf_ff,
                "set state not cleared after output")

endmodule
